>>> hdl/sqlts_pkg.sv
// ---------------------------------------------------------------------------
// SQL token scanner package
// Token, reason and scan mode codes, the keyword table and the response type.
// ---------------------------------------------------------------------------
package sqlts_pkg;

   typedef enum logic [4:0] {
      TK_END     = 5'd0,
      TK_IDENT   = 5'd1,
      TK_NUMBER  = 5'd2,
      TK_STRING  = 5'd3,
      TK_SELECT  = 5'd4,
      TK_FROM    = 5'd5,
      TK_WHERE   = 5'd6,
      TK_INSERT  = 5'd7,
      TK_INTO    = 5'd8,
      TK_VALUES  = 5'd9,
      TK_AND     = 5'd10,
      TK_OR      = 5'd11,
      TK_EQ      = 5'd12,
      TK_NE      = 5'd13,
      TK_LT      = 5'd14,
      TK_LE      = 5'd15,
      TK_GT      = 5'd16,
      TK_GE      = 5'd17,
      TK_COMMA   = 5'd18,
      TK_LPAREN  = 5'd19,
      TK_RPAREN  = 5'd20,
      TK_SEMI    = 5'd21,
      TK_STAR    = 5'd22,
      TK_INVALID = 5'd23
   } token_kind_type;

   typedef enum logic [1:0] {
      RSN_NONE         = 2'd0,
      RSN_UNEXPECTED   = 2'd1,
      RSN_LONE_BANG    = 2'd2,
      RSN_UNTERMINATED = 2'd3
   } reason_type;

   typedef enum logic [6:0] {
      M_IDLE    = 7'b0000001,
      M_NUMBER  = 7'b0000010,
      M_WORD    = 7'b0000100,
      M_STRING  = 7'b0001000,
      M_LESS    = 7'b0010000,
      M_GREATER = 7'b0100000,
      M_BANG    = 7'b1000000
   } mode_type;

   typedef struct packed {
      token_kind_type kind;
      logic [15:0]    start;
      logic [15:0]    length;
      reason_type     reason;
      logic           last;
   } token_type;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_STAR   = 8'h2A;

   localparam int KW_COUNT = 8;
   localparam int KW_CHARS = 6;

   localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
      48'("select"), 48'("from"), 48'("where"), 48'("insert"),
      48'("into"), 48'("values"), 48'("and"), 48'("or")
   };
   localparam int KW_LEN [KW_COUNT] = '{6, 4, 5, 6, 4, 6, 3, 2};

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   function automatic logic [7:0] kw_byte(input int k, input int i);
      return KW_TEXT[k][8 * (KW_LEN[k] - 1 - i) +: 8];
   endfunction

   function automatic token_type make_tok(input token_kind_type kind,
                                          input logic [15:0] start,
                                          input logic [15:0] length,
                                          input reason_type reason);
      token_type t;
      t.kind   = kind;
      t.start  = start;
      t.length = length;
      t.reason = reason;
      t.last   = 1'b0;
      return t;
   endfunction

endpackage

>>> hdl/sql_token_scanner_core.sv
// ---------------------------------------------------------------------------
// SQL token scanner core
// Scans query text one byte per request and emits closed tokens.
// ---------------------------------------------------------------------------
// One request is taken per clock cycle while the queue has room. Each request
// is scanned in the cycle it is accepted and produces zero to three tokens.
// The tokens enter a four-entry result queue and reach the response port
// from the next cycle on, one per response cycle. A request is accepted
// whenever the queue holds at most one token, counted before any response
// leaves in the same cycle. With the response port always ready, requests of
// at most one token each keep one request per cycle, and a request with more
// tokens holds the next one until the queue is down to one token. A stalled
// response port holds the requests once a second token is waiting.
module sql_token_scanner_core
   import sqlts_pkg::*;
#(
   parameter int POSITION_WIDTH  = 16,
   parameter int KEYWORD_MAX_LEN = 6
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_byte,
   input  logic        req_has_char,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic [1:0]  rsp_invalid_reason,
   output logic        rsp_last_of_run
);

   localparam int PW = POSITION_WIDTH;
   localparam int IW = $clog2(KEYWORD_MAX_LEN);
   localparam logic [PW-1:0] POS_MAX = '1;

   mode_type                              mode_ff, mode_in;
   logic [PW-1:0]                         pos_ff, pos_in;
   logic [PW-1:0]                         pstart_ff, pstart_in;
   logic [KEYWORD_MAX_LEN-1:0][7:0]       window_ff, window_in;
   logic                                  too_long_ff, too_long_in;

   logic                                  accept;
   token_type [2:0]                       res;
   logic [1:0]                            n;
   logic                                  taken;
   logic [7:0]                            c;
   logic [7:0]                            lc;
   logic [PW-1:0]                         idx;
   logic                                  space_ok;
   token_type                             head;

   function automatic logic [15:0] sat16(input logic [PW-1:0] v);
      logic [PW+15:0] wide;
      wide = (PW + 16)'(v);
      if (wide > (PW + 16)'(17'h0FFFF)) return 16'hFFFF;
      return wide[15:0];
   endfunction

   function automatic logic [PW-1:0] span(input logic [PW-1:0] from,
                                          input logic [PW-1:0] upto);
      return (upto >= from) ? upto - from : '0;
   endfunction

   function automatic token_kind_type kw_kind(input logic [5:0][7:0] w,
                                              input logic too_long,
                                              input logic [PW-1:0] len);
      token_kind_type kind;
      logic           hit;
      kind = TK_IDENT;
      if (!too_long && len <= PW'(KEYWORD_MAX_LEN)) begin
         for (int k = KW_COUNT - 1; k >= 0; k--) begin
            hit = (len == PW'(KW_LEN[k]));
            for (int i = 0; i < KW_CHARS; i++) begin
               if (i < KW_LEN[k] && w[i] != kw_byte(k, i)) hit = 1'b0;
            end
            if (hit) kind = token_kind_type'(5'(int'(TK_SELECT) + k));
         end
      end
      return kind;
   endfunction

   function automatic token_type close_tok(input mode_type mode,
                                           input logic [PW-1:0] s,
                                           input logic [PW-1:0] p,
                                           input logic [5:0][7:0] w,
                                           input logic too_long);
      token_type t;
      t = make_tok(TK_INVALID, sat16(s), 16'd1, RSN_LONE_BANG);
      unique case (mode)
         M_NUMBER:  t = make_tok(TK_NUMBER, sat16(s), sat16(span(s, p)), RSN_NONE);
         M_WORD:    t = make_tok(kw_kind(w, too_long, span(s, p)), sat16(s),
                                 sat16(span(s, p)), RSN_NONE);
         M_STRING:  t = make_tok(TK_INVALID, sat16(s), sat16(span(s, p)),
                                 RSN_UNTERMINATED);
         M_LESS:    t = make_tok(TK_LT, sat16(s), 16'd1, RSN_NONE);
         M_GREATER: t = make_tok(TK_GT, sat16(s), 16'd1, RSN_NONE);
         default:   t = make_tok(TK_INVALID, sat16(s), 16'd1, RSN_LONE_BANG);
      endcase
      return t;
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   assign accept    = req_valid & req_ready;
   assign req_ready = space_ok;
   assign c         = req_char_byte;
   assign lc        = (c >= "A" && c <= "Z") ? c + 8'd32 : c;

   always_comb begin
      mode_in     = mode_ff;
      pos_in      = pos_ff;
      pstart_in   = pstart_ff;
      window_in   = window_ff;
      too_long_in = too_long_ff;
      res         = '0;
      n           = 2'd0;
      taken       = 1'b0;
      idx         = span(pstart_ff, pos_ff);

      if (accept && req_has_char) begin
         unique case (mode_ff)
            M_STRING: begin
               taken = 1'b1;
               if (c == CH_QUOTE) begin
                  res[n]  = make_tok(TK_STRING, sat16(pstart_ff),
                                     sat16(span(pstart_ff, pos_ff)), RSN_NONE);
                  n       = n + 2'd1;
                  mode_in = M_IDLE;
               end
            end
            M_LESS, M_GREATER, M_BANG: begin
               if (c == CH_EQ) begin
                  res[n]  = make_tok((mode_ff == M_LESS) ? TK_LE :
                                     (mode_ff == M_GREATER) ? TK_GE : TK_NE,
                                     sat16(pstart_ff), 16'd2, RSN_NONE);
                  n       = n + 2'd1;
                  mode_in = M_IDLE;
                  taken   = 1'b1;
               end else begin
                  res[n]  = close_tok(mode_ff, pstart_ff, pos_ff,
                                      window_ff[5:0], too_long_ff);
                  n       = n + 2'd1;
                  mode_in = M_IDLE;
               end
            end
            M_NUMBER: begin
               if (is_digit(c)) begin
                  taken = 1'b1;
               end else begin
                  res[n]  = close_tok(mode_ff, pstart_ff, pos_ff,
                                      window_ff[5:0], too_long_ff);
                  n       = n + 2'd1;
                  mode_in = M_IDLE;
               end
            end
            M_WORD: begin
               if (is_alpha(c) || is_digit(c)) begin
                  taken = 1'b1;
                  if (idx < PW'(KEYWORD_MAX_LEN)) begin
                     window_in[idx[IW-1:0]] = lc;
                  end else begin
                     too_long_in = 1'b1;
                  end
               end else begin
                  res[n]  = close_tok(mode_ff, pstart_ff, pos_ff,
                                      window_ff[5:0], too_long_ff);
                  n       = n + 2'd1;
                  mode_in = M_IDLE;
               end
            end
            default: begin
            end
         endcase

         if (!taken) begin
            unique case (c)
               CH_SPACE, CH_TAB, CH_NL: begin
               end
               CH_QUOTE: begin
                  mode_in   = M_STRING;
                  pstart_in = (pos_ff < POS_MAX) ? pos_ff + PW'(1) : POS_MAX;
               end
               CH_EQ: begin
                  res[n] = make_tok(TK_EQ, sat16(pos_ff), 16'd1, RSN_NONE);
                  n      = n + 2'd1;
               end
               CH_BANG: begin
                  mode_in   = M_BANG;
                  pstart_in = pos_ff;
               end
               CH_LT: begin
                  mode_in   = M_LESS;
                  pstart_in = pos_ff;
               end
               CH_GT: begin
                  mode_in   = M_GREATER;
                  pstart_in = pos_ff;
               end
               CH_COMMA: begin
                  res[n] = make_tok(TK_COMMA, sat16(pos_ff), 16'd1, RSN_NONE);
                  n      = n + 2'd1;
               end
               CH_LPAREN: begin
                  res[n] = make_tok(TK_LPAREN, sat16(pos_ff), 16'd1, RSN_NONE);
                  n      = n + 2'd1;
               end
               CH_RPAREN: begin
                  res[n] = make_tok(TK_RPAREN, sat16(pos_ff), 16'd1, RSN_NONE);
                  n      = n + 2'd1;
               end
               CH_SEMI: begin
                  res[n] = make_tok(TK_SEMI, sat16(pos_ff), 16'd1, RSN_NONE);
                  n      = n + 2'd1;
               end
               CH_STAR: begin
                  res[n] = make_tok(TK_STAR, sat16(pos_ff), 16'd1, RSN_NONE);
                  n      = n + 2'd1;
               end
               default: begin
                  if (is_digit(c)) begin
                     mode_in   = M_NUMBER;
                     pstart_in = pos_ff;
                  end else if (is_alpha(c)) begin
                     mode_in      = M_WORD;
                     pstart_in    = pos_ff;
                     window_in    = '0;
                     window_in[0] = lc;
                     too_long_in  = 1'b0;
                  end else begin
                     res[n] = make_tok(TK_INVALID, sat16(pos_ff), 16'd1,
                                       RSN_UNEXPECTED);
                     n      = n + 2'd1;
                  end
               end
            endcase
         end

         pos_in = (pos_ff < POS_MAX) ? pos_ff + PW'(1) : pos_ff;
      end

      if (accept && req_end_of_input) begin
         if (mode_in != M_IDLE) begin
            res[n] = close_tok(mode_in, pstart_in, pos_in, window_in[5:0],
                               too_long_in);
            n      = n + 2'd1;
         end
         res[n]      = make_tok(TK_END, sat16(pos_in), 16'd0, RSN_NONE);
         n           = n + 2'd1;
         mode_in     = M_IDLE;
         pos_in      = '0;
         pstart_in   = '0;
         window_in   = '0;
         too_long_in = 1'b0;
      end

      if (n != 2'd0) begin
         res[n - 2'd1].last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= M_IDLE;
         pos_ff      <= '0;
         pstart_ff   <= '0;
         window_ff   <= '0;
         too_long_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         pos_ff      <= pos_in;
         pstart_ff   <= pstart_in;
         window_ff   <= window_in;
         too_long_ff <= too_long_in;
      end
   end

   sqlts_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (accept ? n : 2'd0),
      .push_data  (res),
      .space_ok   (space_ok),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (head)
   );

   assign rsp_token_kind     = head.kind;
   assign rsp_token_start    = head.start;
   assign rsp_token_length   = head.length;
   assign rsp_invalid_reason = head.reason;
   assign rsp_last_of_run    = head.last;

   a_end_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_input) |=> (pos_ff == '0 && mode_ff == M_IDLE))
      else $error("end of input did not restart the scan");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      (accept && req_has_char && !req_end_of_input && pos_ff != POS_MAX)
      |=> pos_ff == $past(pos_ff) + PW'(1))
      else $error("byte offset did not advance");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(pos_ff) && $stable(mode_ff))
      else $error("scan state moved without a request");

endmodule

>>> hdl/sqlts_result_queue.sv
// ---------------------------------------------------------------------------
// SQL token scanner result queue
// Takes up to three tokens per cycle and hands them out one per response.
// ---------------------------------------------------------------------------
module sqlts_result_queue
   import sqlts_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_count,
   input  token_type [2:0]     push_data,
   output logic                space_ok,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output token_type           rsp_data
);

   token_type               mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   logic                    pop;

   assign space_ok  = count_ff <= QCNT_W'(QUEUE_DEPTH - 3);
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid & rsp_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(push_count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         if (2'(j) < push_count) begin
            mem_ff[wr_ptr_ff + QPTR_W'(j)] <= push_data[j];
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_push_space: assert property (@(posedge clock) disable iff (reset)
      push_count != 2'd0 |-> space_ok)
      else $error("push without room for a full request");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push_count == 2'd0 && !pop) |=> $stable(count_ff))
      else $error("count moved without push or pop");

endmodule

>>> dv/tb_sql_token_scanner_core.sv
// ---------------------------------------------------------------------------
// SQL token scanner core testbench
// Drives query text into the scanner byte by byte, predicts each token from
// its own scanner or a typed row, and compares the response port field by
// field. A short directed script is followed by random well-formed queries
// with noise and a closing stretch with no idling on either side.
// ---------------------------------------------------------------------------
module tb_sql_token_scanner_core
   import sqlts_pkg::*;
();

   localparam int          WORD_WINDOW  = 6;
   localparam logic [15:0] POS_TOP      = 16'hFFFF;
   localparam int          RANDOM_ITEMS = 110;
   localparam int          CALM_ITEMS   = 40;
   localparam int          STALL_LIMIT  = 2000;

   typedef struct {
      logic [7:0] ch;
      logic       has;
      logic       eoi;
      logic       typed;
      token_type  known;
   } script_row_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_byte    = 8'h00;
   logic        req_has_char     = 1'b0;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [4:0]  rsp_token_kind;
   logic [15:0] rsp_token_start;
   logic [15:0] rsp_token_length;
   logic [1:0]  rsp_invalid_reason;
   logic        rsp_last_of_run;

   // typed expectation travels with the request it belongs to
   logic        row_typed = 1'b0;
   token_type   row_known = '0;

   string sql_words [8] = '{"select", "from", "where", "insert",
                            "into", "values", "and", "or"};
   string cmp_ops   [7] = '{"=", "!=", "<", "<=", ">", ">=", "!"};

   // scanner prediction state
   mode_type    scan_state;
   logic [15:0] scan_pos;
   logic [15:0] token_origin;
   logic [7:0]  word_head [WORD_WINDOW];
   logic        word_overflow;
   token_type   step_out [$];
   token_type   tokens_due [$];

   script_row_type script [$];
   logic [7:0]     query_text [$];

   int idle_odds   = 0;
   int rx_odds     = 0;
   int rx_hold     = 0;
   int fail_count  = 0;
   int req_count   = 0;
   int tok_count   = 0;
   int sent_items  = 0;
   int query_count = 0;

   sql_token_scanner_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_byte      (req_char_byte),
      .req_has_char       (req_has_char),
      .req_end_of_input   (req_end_of_input),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_token_kind     (rsp_token_kind),
      .rsp_token_start    (rsp_token_start),
      .rsp_token_length   (rsp_token_length),
      .rsp_invalid_reason (rsp_invalid_reason),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] span_of(logic [15:0] from_pos, logic [15:0] to_pos);
      return (to_pos >= from_pos) ? to_pos - from_pos : 16'd0;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic void add_token(token_kind_type kind, logic [15:0] start,
                                     logic [15:0] len, reason_type why);
      token_type t;
      t = '{kind, start, len, why, 1'b0};
      step_out = {step_out, t};
   endfunction

   function automatic void text_add(logic [7:0] c);
      query_text = {query_text, c};
   endfunction

   function automatic void scanner_clear();
      scan_state    = M_IDLE;
      scan_pos      = '0;
      token_origin  = '0;
      word_overflow = 1'b0;
      foreach (word_head[i]) word_head[i] = 8'h00;
   endfunction

   function automatic void word_store(logic [7:0] c, logic [15:0] idx);
      logic [7:0] lc;
      lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      if (idx < WORD_WINDOW) word_head[idx[2:0]] = lc;
      else word_overflow = 1'b1;
   endfunction

   function automatic token_kind_type word_kind(logic [15:0] len);
      token_kind_type kind;
      logic           same;
      kind = TK_IDENT;
      if (!word_overflow && len <= WORD_WINDOW) begin
         for (int k = 0; k < 8; k++) begin
            if (sql_words[k].len() == len) begin
               same = 1'b1;
               for (int i = 0; i < len; i++) begin
                  if (word_head[i] != sql_words[k][i]) same = 1'b0;
               end
               if (same) kind = token_kind_type'(TK_SELECT + k);
            end
         end
      end
      return kind;
   endfunction

   function automatic void close_open(logic [15:0] p);
      case (scan_state)
         M_NUMBER:  add_token(TK_NUMBER, token_origin, span_of(token_origin, p), RSN_NONE);
         M_WORD:    add_token(word_kind(span_of(token_origin, p)), token_origin,
                              span_of(token_origin, p), RSN_NONE);
         M_STRING:  add_token(TK_INVALID, token_origin, span_of(token_origin, p),
                              RSN_UNTERMINATED);
         M_LESS:    add_token(TK_LT, token_origin, 16'd1, RSN_NONE);
         M_GREATER: add_token(TK_GT, token_origin, 16'd1, RSN_NONE);
         M_BANG:    add_token(TK_INVALID, token_origin, 16'd1, RSN_LONE_BANG);
         default: ;
      endcase
      scan_state = M_IDLE;
   endfunction

   function automatic void open_token(logic [7:0] c, logic [15:0] p);
      case (c)
         CH_SPACE, CH_TAB, CH_NL: ;
         CH_QUOTE: begin
            scan_state   = M_STRING;
            token_origin = (p != POS_TOP) ? p + 16'd1 : POS_TOP;
         end
         CH_EQ:     add_token(TK_EQ, p, 16'd1, RSN_NONE);
         CH_BANG: begin
            scan_state   = M_BANG;
            token_origin = p;
         end
         CH_LT: begin
            scan_state   = M_LESS;
            token_origin = p;
         end
         CH_GT: begin
            scan_state   = M_GREATER;
            token_origin = p;
         end
         CH_COMMA:  add_token(TK_COMMA, p, 16'd1, RSN_NONE);
         CH_LPAREN: add_token(TK_LPAREN, p, 16'd1, RSN_NONE);
         CH_RPAREN: add_token(TK_RPAREN, p, 16'd1, RSN_NONE);
         CH_SEMI:   add_token(TK_SEMI, p, 16'd1, RSN_NONE);
         CH_STAR:   add_token(TK_STAR, p, 16'd1, RSN_NONE);
         default: begin
            if (is_digit(c)) begin
               scan_state   = M_NUMBER;
               token_origin = p;
            end else if (is_letter(c)) begin
               scan_state    = M_WORD;
               token_origin  = p;
               word_overflow = 1'b0;
               foreach (word_head[i]) word_head[i] = 8'h00;
               word_store(c, 16'd0);
            end else begin
               add_token(TK_INVALID, p, 16'd1, RSN_UNEXPECTED);
            end
         end
      endcase
   endfunction

   function automatic void scan_char(logic [7:0] c);
      logic [15:0] p;
      logic        taken;
      p     = scan_pos;
      taken = 1'b0;
      case (scan_state)
         M_STRING: begin
            if (c == CH_QUOTE) begin
               add_token(TK_STRING, token_origin, span_of(token_origin, p), RSN_NONE);
               scan_state = M_IDLE;
            end
            taken = 1'b1;
         end
         M_LESS, M_GREATER, M_BANG: begin
            if (c == CH_EQ) begin
               add_token(scan_state == M_LESS ? TK_LE :
                         scan_state == M_GREATER ? TK_GE : TK_NE,
                         token_origin, 16'd2, RSN_NONE);
               scan_state = M_IDLE;
               taken      = 1'b1;
            end else begin
               close_open(p);
            end
         end
         M_NUMBER: begin
            if (is_digit(c)) taken = 1'b1;
            else close_open(p);
         end
         M_WORD: begin
            if (is_letter(c) || is_digit(c)) begin
               word_store(c, span_of(token_origin, p));
               taken = 1'b1;
            end else begin
               close_open(p);
            end
         end
         default: ;
      endcase
      if (!taken) open_token(c, p);
      if (scan_pos != POS_TOP) scan_pos = scan_pos + 16'd1;
   endfunction

   function automatic void predict_tokens(logic [7:0] c, logic has, logic eoi,
                                          logic typed, token_type known);
      step_out.delete();
      if (has) scan_char(c);
      if (eoi) begin
         close_open(scan_pos);
         add_token(TK_END, scan_pos, 16'd0, RSN_NONE);
         scanner_clear();
      end
      if (typed) begin
         step_out.delete();
         step_out = {step_out, known};
      end
      if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) tokens_due = {tokens_due, step_out[i]};
   endfunction

   function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: token %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : port_watch
      token_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_count++;
            predict_tokens(req_char_byte, req_has_char, req_end_of_input,
                           row_typed, row_known);
         end
         if (rsp_valid && rsp_ready) begin
            tok_count++;
            if (tokens_due.size() == 0) begin
               $display("%0t: token kind %0d start %0d length %0d with none expected",
                        $time, rsp_token_kind, rsp_token_start, rsp_token_length);
               fail_count++;
            end else begin
               want = tokens_due.pop_front();
               compare_field("kind", 16'(want.kind), 16'(rsp_token_kind));
               compare_field("start", want.start, rsp_token_start);
               compare_field("length", want.length, rsp_token_length);
               compare_field("reason", 16'(want.reason), 16'(rsp_invalid_reason));
               compare_field("last", 16'(want.last), 16'(rsp_last_of_run));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (rx_hold != 0) begin
         rx_hold <= rx_hold - 1;
      end else if (rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
         rsp_ready <= 1'b0;
         rx_hold   <= $urandom_range(0, 18);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no request or token moved for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
   end

   function automatic logic [7:0] pick(string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   function automatic logic [7:0] non_quote();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      return (c == CH_QUOTE) ? 8'h00 : c;
   endfunction

   function automatic void add_row(logic [7:0] ch, logic has, logic eoi,
                                   logic typed = 1'b0, token_kind_type kind = TK_END,
                                   logic [15:0] start = '0, logic [15:0] len = '0,
                                   reason_type why = RSN_NONE);
      script_row_type r;
      r.ch    = ch;
      r.has   = has;
      r.eoi   = eoi;
      r.typed = typed;
      r.known = '{kind, start, len, why, 1'b1};
      script = {script, r};
   endfunction

   task automatic send_request(input logic [7:0] ch, input logic has, input logic eoi,
                               input logic typed = 1'b0, input token_type known = '0);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_char_byte    <= ch;
      req_has_char     <= has;
      req_end_of_input <= eoi;
      row_typed        <= typed;
      row_known        <= known;
      if (has || eoi) sent_items++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic compose_query();
      string      w;
      logic [7:0] c;
      query_text.delete();
      repeat ($urandom_range(1, 8)) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               // keyword in mixed case, sometimes grown into an identifier
               w = sql_words[$urandom_range(0, 7)];
               for (int i = 0; i < w.len(); i++) begin
                  c = w[i];
                  if ($urandom_range(0, 1)) c = c - 8'h20;
                  text_add(c);
               end
               if ($urandom_range(0, 3) == 0) begin
                  repeat ($urandom_range(1, 3))
                     text_add(pick("abcXYZ_019"));
               end
            end
            3: begin
               text_add(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
               repeat ($urandom_range(0, 9))
                  text_add(pick("aeiostwxzAEIOSTWXZ_0123456789"));
            end
            4: repeat ($urandom_range(1, 6)) text_add(pick("0123456789"));
            5: begin
               text_add(CH_QUOTE);
               repeat ($urandom_range(0, 8)) text_add(non_quote());
               text_add(CH_QUOTE);
            end
            6: begin
               w = cmp_ops[$urandom_range(0, 6)];
               for (int i = 0; i < w.len(); i++) text_add(w[i]);
            end
            7: text_add(pick(",();*"));
            8: text_add(8'($urandom_range(0, 255)));
            default: text_add(pick(" \t\n"));
         endcase
         if ($urandom_range(0, 2) != 0) text_add(pick(" \t\n"));
      end
      // leave a string open at the end now and then
      if ($urandom_range(0, 5) == 0) begin
         text_add(CH_QUOTE);
         repeat ($urandom_range(0, 4)) text_add(non_quote());
      end
   endtask

   task automatic send_query();
      int n;
      int ending;
      n      = query_text.size();
      ending = (n == 0) ? 1 : $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_request(query_text[i], 1'b1, (i == n - 1) && (ending == 0));
      end
      if (ending != 0) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      query_count++;
   endtask

   initial begin
      int goal;
      scanner_clear();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_row(CH_EQ, 1'b1, 1'b0, 1'b1, TK_EQ, 16'd0, 16'd1);
      add_row(8'h00, 1'b1, 1'b0, 1'b1, TK_INVALID, 16'd1, 16'd1, RSN_UNEXPECTED);
      add_row(8'hFF, 1'b1, 1'b0, 1'b1, TK_INVALID, 16'd2, 16'd1, RSN_UNEXPECTED);
      add_row(CH_BANG, 1'b1, 1'b0);
      add_row("x", 1'b1, 1'b0);
      add_row(8'h5A, 1'b0, 1'b0);
      add_row(CH_BANG, 1'b1, 1'b0);
      add_row(CH_EQ, 1'b1, 1'b0);
      add_row(CH_LT, 1'b1, 1'b0);
      add_row(CH_GT, 1'b1, 1'b0);
      add_row(CH_EQ, 1'b1, 1'b0);
      add_row(CH_LT, 1'b1, 1'b0);
      add_row(CH_EQ, 1'b1, 1'b0);
      add_row(CH_GT, 1'b1, 1'b0);
      add_row(CH_TAB, 1'b1, 1'b0);
      add_row(CH_COMMA, 1'b1, 1'b0, 1'b1, TK_COMMA, 16'd14, 16'd1);
      add_row(CH_LPAREN, 1'b1, 1'b0, 1'b1, TK_LPAREN, 16'd15, 16'd1);
      add_row(CH_RPAREN, 1'b1, 1'b0, 1'b1, TK_RPAREN, 16'd16, 16'd1);
      add_row(CH_SEMI, 1'b1, 1'b0, 1'b1, TK_SEMI, 16'd17, 16'd1);
      add_row(CH_STAR, 1'b1, 1'b0, 1'b1, TK_STAR, 16'd18, 16'd1);
      add_row("9", 1'b1, 1'b0);
      add_row(CH_QUOTE, 1'b1, 1'b0);
      add_row(CH_NL, 1'b1, 1'b0);
      add_row(8'hA5, 1'b0, 1'b1);
      add_row("7", 1'b1, 1'b1);
      add_row(CH_BANG, 1'b1, 1'b1);
      add_row(8'h00, 1'b0, 1'b1, 1'b1, TK_END, 16'd0, 16'd0);

      idle_odds = 4;
      rx_odds   = 6;
      foreach (script[i])
         send_request(script[i].ch, script[i].has, script[i].eoi,
                      script[i].typed, script[i].known);
      query_count++;

      goal = sent_items + RANDOM_ITEMS;
      while (sent_items < goal) begin
         case ($urandom_range(0, 2))
            0: idle_odds = 0;
            1: idle_odds = 3;
            default: idle_odds = 8;
         endcase
         case ($urandom_range(0, 2))
            0: rx_odds = 0;
            1: rx_odds = 4;
            default: rx_odds = 12;
         endcase
         compose_query();
         send_query();
      end

      idle_odds = 0;
      rx_odds   = 0;
      goal      = sent_items + CALM_ITEMS;
      while (sent_items < goal) begin
         compose_query();
         send_query();
      end

      req_valid <= 1'b0;
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Scanned %0d requests over %0d queries, directed and random.",
               req_count, query_count);
      $display("Compared %0d tokens with the predicted stream, %0d field errors.",
               tok_count, fail_count);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
